### hw/rtl/rhep_pkg.sv
// rhep_pkg: shared types and constants for the RTP one-byte header
// extension parser. No dependencies; used by the interfaces and all modules.
package rhep_pkg;

  localparam int BYTE_W      = 8;
  localparam int ID_W        = 4;
  localparam int STATUS_W    = 3;
  localparam int OFF_W       = 19;
  localparam int CNT_W       = 14;
  localparam int WORD_W      = 32;
  localparam int LEVEL_W     = 7;
  localparam int HALF_W      = 16;

  localparam int MAX_PACKET_BYTES_DEF = 16384;

  localparam logic [OFF_W-1:0]  FIXED_HDR_BYTES  = OFF_W'(12);
  localparam logic [OFF_W-1:0]  EXT_HDR_BYTES    = OFF_W'(4);
  localparam logic [HALF_W-1:0] ONE_BYTE_PROFILE = 16'hBEDE;
  localparam logic [ID_W-1:0]   STOP_ID          = 4'hF;
  localparam logic [ID_W-1:0]   PAD_ID           = 4'h0;
  localparam logic [CNT_W-1:0]  CNT_MAX          = '1;
  localparam logic [ID_W-1:0]   TARGET_ID_RST    = 4'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_OVERRUN     = 3'd2,
    ST_BAD_PROFILE = 3'd3,
    ST_TOO_LONG    = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } beat_t;

  typedef struct packed {
    status_t           status;
    logic [OFF_W-1:0]  offset;
    logic [CNT_W-1:0]  count;
    logic              found;
    logic [WORD_W-1:0] word;
  } res_t;

endpackage

### hw/rtl/rhep_in_if.sv
// rhep_in_if: packet byte channel (valid/ready plus one byte and end mark).
// Depends on rhep_pkg.
interface rhep_in_if;
  logic                       valid;
  logic                       ready;
  logic [rhep_pkg::BYTE_W-1:0] packet_byte;
  logic                       last_byte;

  modport source (output valid, packet_byte, last_byte, input ready);
  modport sink   (input valid, packet_byte, last_byte, output ready);
endinterface

### hw/rtl/rhep_out_if.sv
// rhep_out_if: per-packet result channel (valid/ready plus result fields).
// Depends on rhep_pkg.
interface rhep_out_if;
  logic                         valid;
  logic                         ready;
  logic [rhep_pkg::STATUS_W-1:0] status;
  logic [rhep_pkg::OFF_W-1:0]    payload_offset;
  logic [rhep_pkg::CNT_W-1:0]    extension_count;
  logic                         id_found;
  logic [rhep_pkg::BYTE_W-1:0]   element_first_byte;
  logic [rhep_pkg::WORD_W-1:0]   element_word;
  logic [rhep_pkg::LEVEL_W-1:0]  audio_level;
  logic                         voice_flag;

  modport source (output valid, status, payload_offset, extension_count, id_found,
                  element_first_byte, element_word, audio_level, voice_flag,
                  input ready);
  modport sink   (input valid, status, payload_offset, extension_count, id_found,
                  element_first_byte, element_word, audio_level, voice_flag,
                  output ready);
endinterface

### hw/rtl/rhep_core.sv
// rhep_core: per-packet parse state and the per-beat header/element walk.
// Produces the packet result in the cycle its final beat is processed.
// Depends on rhep_pkg.
module rhep_core #(
  parameter int MAX_PACKET_BYTES = rhep_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rhep_pkg::ID_W-1:0]  target_id,
  input  logic                       fire,
  input  rhep_pkg::beat_t            beat,
  output logic                       res_valid,
  output rhep_pkg::res_t             res
);

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET_BYTES);
  localparam int OW = rhep_pkg::OFF_W;
  localparam int CW = rhep_pkg::CNT_W;

  logic [POS_W-1:0]            pos_r, pos_nxt;
  logic [3:0]                  csrc_r, csrc_upd, csrc_nxt;
  logic                        ext_r, ext_upd, ext_nxt;
  logic [15:0]                 profile_r, profile_upd, profile_nxt;
  logic [15:0]                 words_r, words_upd, words_nxt;
  logic [OW-1:0]               cursor_r, cursor_upd, cursor_nxt;
  logic                        stopped_r, stopped_upd, stopped_nxt;
  logic [rhep_pkg::CNT_W-1:0]  total_r, total_upd, total_nxt;
  logic                        match_r, match_upd, match_nxt;
  logic [31:0]                 cap_r, cap_upd, cap_nxt;
  logic [2:0]                  capidx_r, capidx_upd, capidx_nxt;

  logic          live;
  logic [OW-1:0] p, h, e_cur, h_fin, e_fin, len;
  logic [3:0]    id;
  logic [7:0]    b;

  assign b     = beat.data;
  assign id    = b[7:4];
  assign live  = pos_r < MAX_POS;
  assign p     = OW'(pos_r);
  assign h     = rhep_pkg::FIXED_HDR_BYTES + OW'({csrc_r, 2'b00});
  assign e_cur = h + rhep_pkg::EXT_HDR_BYTES + OW'({words_r, 2'b00});

  // per-beat update of the walk
  always_comb begin
    csrc_upd    = csrc_r;
    ext_upd     = ext_r;
    profile_upd = profile_r;
    words_upd   = words_r;
    cursor_upd  = cursor_r;
    stopped_upd = stopped_r;
    total_upd   = total_r;
    match_upd   = match_r;
    cap_upd     = cap_r;
    capidx_upd  = capidx_r;
    if (live) begin
      if (p == '0) begin
        csrc_upd = b[3:0];
        ext_upd  = b[4];
      end else begin
        if (ext_r) begin
          if (p == h) begin
            profile_upd[15:8] = b;
          end else if (p == h + OW'(1)) begin
            profile_upd[7:0] = b;
          end else if (p == h + OW'(2)) begin
            words_upd[15:8] = b;
          end else if (p == h + OW'(3)) begin
            words_upd[7:0] = b;
            cursor_upd     = h + rhep_pkg::EXT_HDR_BYTES;
          end
        end
        if (capidx_r >= 3'd1 && capidx_r <= 3'd3) begin
          capidx_upd = capidx_r + 3'd1;
          unique case (capidx_r[1:0])
            2'd1:    cap_upd[23:16] = cap_r[23:16] | b;
            2'd2:    cap_upd[15:8]  = cap_r[15:8]  | b;
            default: cap_upd[7:0]   = cap_r[7:0]   | b;
          endcase
        end
        if (ext_r && cursor_r != '0 && !stopped_r && p == cursor_r && p < e_cur) begin
          if (id == rhep_pkg::STOP_ID) begin
            stopped_upd = 1'b1;
          end else if (id == rhep_pkg::PAD_ID) begin
            cursor_upd = p + OW'(1);
          end else begin
            if (total_r < rhep_pkg::CNT_MAX) begin
              total_upd = total_r + CW'(1);
            end
            if (id == target_id && !match_r) begin
              match_upd  = 1'b1;
              cap_upd    = {b, 24'd0};
              capidx_upd = 3'd1;
            end
            cursor_upd = p + OW'(2) + OW'(b[3:0]);
          end
        end
      end
    end
  end

  // packet result on the final beat
  assign h_fin = rhep_pkg::FIXED_HDR_BYTES + OW'({csrc_upd, 2'b00});
  assign e_fin = h_fin + rhep_pkg::EXT_HDR_BYTES + OW'({words_upd, 2'b00});
  assign len   = p + OW'(1);

  always_comb begin
    res        = '0;
    res.status = rhep_pkg::ST_OK;
    if (!live) begin
      res.status = rhep_pkg::ST_TOO_LONG;
      res.offset = ext_upd ? e_fin : h_fin;
    end else if (len < rhep_pkg::FIXED_HDR_BYTES) begin
      res.status = rhep_pkg::ST_SHORT;
    end else begin
      res.offset = ext_upd ? e_fin : h_fin;
      if (ext_upd) begin
        if (len < e_fin) begin
          res.status = rhep_pkg::ST_OVERRUN;
        end else if (profile_upd != rhep_pkg::ONE_BYTE_PROFILE) begin
          res.status = rhep_pkg::ST_BAD_PROFILE;
        end else begin
          res.count = total_upd;
          if (match_upd && len > e_fin) begin
            res.found = 1'b1;
            res.word  = cap_upd;
          end
        end
      end
    end
  end

  assign res_valid = fire && beat.last;

  always_comb begin
    pos_nxt     = pos_r;
    csrc_nxt    = csrc_r;
    ext_nxt     = ext_r;
    profile_nxt = profile_r;
    words_nxt   = words_r;
    cursor_nxt  = cursor_r;
    stopped_nxt = stopped_r;
    total_nxt   = total_r;
    match_nxt   = match_r;
    cap_nxt     = cap_r;
    capidx_nxt  = capidx_r;
    if (fire) begin
      if (beat.last) begin
        pos_nxt     = '0;
        csrc_nxt    = '0;
        ext_nxt     = 1'b0;
        profile_nxt = '0;
        words_nxt   = '0;
        cursor_nxt  = '0;
        stopped_nxt = 1'b0;
        total_nxt   = '0;
        match_nxt   = 1'b0;
        cap_nxt     = '0;
        capidx_nxt  = '0;
      end else begin
        pos_nxt     = live ? pos_r + POS_W'(1) : pos_r;
        csrc_nxt    = csrc_upd;
        ext_nxt     = ext_upd;
        profile_nxt = profile_upd;
        words_nxt   = words_upd;
        cursor_nxt  = cursor_upd;
        stopped_nxt = stopped_upd;
        total_nxt   = total_upd;
        match_nxt   = match_upd;
        cap_nxt     = cap_upd;
        capidx_nxt  = capidx_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      csrc_r    <= '0;
      ext_r     <= 1'b0;
      profile_r <= '0;
      words_r   <= '0;
      cursor_r  <= '0;
      stopped_r <= 1'b0;
      total_r   <= '0;
      match_r   <= 1'b0;
      cap_r     <= '0;
      capidx_r  <= '0;
    end else begin
      pos_r     <= pos_nxt;
      csrc_r    <= csrc_nxt;
      ext_r     <= ext_nxt;
      profile_r <= profile_nxt;
      words_r   <= words_nxt;
      cursor_r  <= cursor_nxt;
      stopped_r <= stopped_nxt;
      total_r   <= total_nxt;
      match_r   <= match_nxt;
      cap_r     <= cap_nxt;
      capidx_r  <= capidx_nxt;
    end
  end

endmodule

### hw/rtl/rtp_header_extension_parser_unit.sv
// rtp_header_extension_parser_unit: top level of the RTP one-byte header
// extension parser. Depends on rhep_pkg, rhep_in_if, rhep_out_if, rhep_core.
//
//   channel   dir  handshake        beat
//   in_if     in   valid/ready      one packet byte, end-of-packet mark
//   out_if    out  valid/ready      one result per packet
//   cfg_*     in   cfg_we only      target element ID
//
// One byte per cycle sustained while no final beat is stalled: input register,
// then the walk update in rhep_core, then the result register.
// Synchronous active-low reset; target ID resets to 1.
// A waiting result stalls only final beats; a stalled one also holds back input.
module rtp_header_extension_parser_unit #(
  parameter int MAX_PACKET_BYTES = rhep_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  rhep_in_if.sink                    in_if,
  rhep_out_if.source                 out_if,
  input  logic                       cfg_we,
  input  logic [rhep_pkg::ID_W-1:0]  cfg_wdata
);

  logic [rhep_pkg::ID_W-1:0] target_id_r;
  logic                      s1_valid_r, s1_valid_nxt;
  rhep_pkg::beat_t           s1_beat_r;
  logic                      out_valid_r, out_valid_nxt;
  rhep_pkg::res_t            out_res_r;
  logic                      accept, out_free, s1_go, core_fire, res_valid;
  rhep_pkg::res_t            core_res;

  assign out_free  = !out_valid_r || out_if.ready;
  assign s1_go     = !s1_beat_r.last || out_free;
  assign core_fire = s1_valid_r && s1_go;
  assign in_if.ready = !s1_valid_r || s1_go;
  assign accept    = in_if.valid && in_if.ready;

  assign s1_valid_nxt  = accept || (s1_valid_r && !s1_go);
  assign out_valid_nxt = res_valid || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_id_r <= rhep_pkg::TARGET_ID_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        target_id_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_beat_r.data <= in_if.packet_byte;
      s1_beat_r.last <= in_if.last_byte;
    end
    if (res_valid) begin
      out_res_r <= core_res;
    end
  end

  rhep_core #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .target_id (target_id_r),
    .fire      (core_fire),
    .beat      (s1_beat_r),
    .res_valid (res_valid),
    .res       (core_res)
  );

  assign out_if.valid              = out_valid_r;
  assign out_if.status             = out_res_r.status;
  assign out_if.payload_offset     = out_res_r.offset;
  assign out_if.extension_count    = out_res_r.count;
  assign out_if.id_found           = out_res_r.found;
  assign out_if.element_word       = out_res_r.word;
  assign out_if.element_first_byte = out_res_r.word[23:16];
  assign out_if.audio_level        = out_res_r.word[22:16];
  assign out_if.voice_flag         = out_res_r.word[23];

`ifndef SYNTHESIS
  a_result_follows_final_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(core_fire && s1_beat_r.last))
    else $error("result raised without a processed final beat");

  a_ready_low_only_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (s1_valid_r && s1_beat_r.last && out_valid_r))
    else $error("input stalled without a blocked final beat");

  a_short_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status == rhep_pkg::ST_SHORT) |->
      (out_if.payload_offset == '0 && out_if.extension_count == '0 && !out_if.id_found))
    else $error("short packet result carries data");

  a_word_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.id_found) |-> (out_if.element_word == '0))
    else $error("element word set without a match");
`endif

endmodule
